>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL files; the queue includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SMM_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define SMM_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

>>> rtl/core/smm_pkg.sv
// Shared codes and types of the segmented memory manager.
package smm_pkg;

    localparam logic [2:0] CMD_MAP      = 3'd0;
    localparam logic [2:0] CMD_UNMAP    = 3'd1;
    localparam logic [2:0] CMD_LOAD     = 3'd2;
    localparam logic [2:0] CMD_STORE    = 3'd3;
    localparam logic [2:0] CMD_LOADPROG = 3'd4;
    localparam logic [2:0] CMD_LENGTH   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_UNMAPPED = 3'd2;
    localparam logic [2:0] ST_OFFSET   = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        OP_RESP,
        OP_LOAD,
        OP_STORE,
        OP_FILL,
        OP_COPY
    } op_kind_t;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  status;
    } rsp_t;

endpackage

>>> rtl/core/smm_front.sv
// Front end: accepts requests, keeps segment bookkeeping and issues word operations.
module smm_front #(
    parameter int SEGMENT_SLOTS = 256,
    parameter int SEGMENT_WORDS = 1024,
    parameter int SLOT_W        = $clog2(SEGMENT_SLOTS),
    parameter int LEN_W         = $clog2(SEGMENT_WORDS + 1),
    parameter int ADDR_W        = $clog2(longint'(SEGMENT_SLOTS) * longint'(SEGMENT_WORDS))
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_command,
    input  logic [7:0]            s_segment_id,
    input  logic [9:0]            s_offset,
    input  logic [31:0]           s_value,
    input  logic [10:0]           s_length,
    input  logic                  q_full,
    output logic                  q_push,
    output smm_pkg::op_kind_t     op_kind,
    output logic [ADDR_W-1:0]     op_addr,
    output logic [LEN_W-1:0]      op_count,
    output logic [31:0]           op_value,
    output smm_pkg::rsp_t         op_rsp
);

    localparam int CNT_W = $clog2(SEGMENT_SLOTS + 1);
    localparam logic [ADDR_W-1:0] WORDS_A = ADDR_W'(SEGMENT_WORDS);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             cmd_reg;
    logic [7:0]             id_reg;
    logic [9:0]             off_reg;
    logic [31:0]            val_reg;
    logic [10:0]            len_reg;
    logic [SEGMENT_SLOTS-1:0] in_use_reg, in_use_next;
    logic [CNT_W-1:0]       free_count_reg, free_count_next;
    logic [CNT_W-1:0]       mapped_count_reg, mapped_count_next;

    logic [LEN_W-1:0]       size_mem [SEGMENT_SLOTS];
    logic [SLOT_W-1:0]      stack_mem [SEGMENT_SLOTS];
    logic [LEN_W-1:0]       size_rd_reg;
    logic [SLOT_W-1:0]      stack_rd_reg;

    logic                   size_we, stack_we;
    logic [SLOT_W-1:0]      size_wa, stack_wa, stack_wd;
    logic [LEN_W-1:0]       size_wd;

    logic                   accept, commit, mapped;
    logic [SLOT_W-1:0]      idx, slot;
    logic [ADDR_W-1:0]      base;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == S_EXEC) && !q_full;
    assign idx     = SLOT_W'({24'b0, id_reg});
    assign mapped  = ({24'b0, id_reg} < 32'(SEGMENT_SLOTS)) && in_use_reg[idx];
    assign base    = ADDR_W'(idx) * WORDS_A;
    assign op_value = val_reg;

    always_comb begin
        state_next        = state_reg;
        in_use_next       = in_use_reg;
        free_count_next   = free_count_reg;
        mapped_count_next = mapped_count_reg;
        q_push   = 1'b0;
        op_kind  = smm_pkg::OP_RESP;
        op_addr  = '0;
        op_count = '0;
        op_rsp   = '{data: 32'd0, status: smm_pkg::ST_OK};
        size_we  = 1'b0;
        size_wa  = '0;
        size_wd  = '0;
        stack_we = 1'b0;
        stack_wa = SLOT_W'(free_count_reg);
        stack_wd = idx;
        slot     = SLOT_W'(mapped_count_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                q_push = !q_full;
                if (commit) state_next = S_IDLE;
                case (cmd_reg)
                    smm_pkg::CMD_MAP: begin
                        if (32'(len_reg) > 32'(SEGMENT_WORDS)) begin
                            op_rsp.status = smm_pkg::ST_LENGTH;
                        end else if (free_count_reg == '0 &&
                                     mapped_count_reg == CNT_W'(SEGMENT_SLOTS)) begin
                            op_rsp.status = smm_pkg::ST_FULL;
                        end else begin
                            if (free_count_reg != '0) slot = stack_rd_reg;
                            op_kind     = smm_pkg::OP_FILL;
                            op_addr     = ADDR_W'(slot) * WORDS_A;
                            op_count    = LEN_W'(len_reg);
                            op_rsp.data = 32'(slot);
                            size_we     = commit;
                            size_wa     = slot;
                            size_wd     = LEN_W'(len_reg);
                            if (commit) begin
                                in_use_next[slot] = 1'b1;
                                mapped_count_next = mapped_count_reg + 1'b1;
                                if (free_count_reg != '0)
                                    free_count_next = free_count_reg - 1'b1;
                            end
                        end
                    end
                    smm_pkg::CMD_UNMAP: begin
                        if (!mapped) begin
                            op_rsp.status = smm_pkg::ST_UNMAPPED;
                        end else if (commit) begin
                            in_use_next[idx] = 1'b0;
                            if (free_count_reg < CNT_W'(SEGMENT_SLOTS)) begin
                                stack_we        = 1'b1;
                                free_count_next = free_count_reg + 1'b1;
                            end
                            if (mapped_count_reg != '0)
                                mapped_count_next = mapped_count_reg - 1'b1;
                        end
                    end
                    smm_pkg::CMD_LOAD, smm_pkg::CMD_STORE: begin
                        if (!mapped) begin
                            op_rsp.status = smm_pkg::ST_UNMAPPED;
                        end else if (32'(off_reg) >= 32'(size_rd_reg)) begin
                            op_rsp.status = smm_pkg::ST_OFFSET;
                        end else begin
                            op_kind = (cmd_reg == smm_pkg::CMD_LOAD) ?
                                      smm_pkg::OP_LOAD : smm_pkg::OP_STORE;
                            op_addr = base + ADDR_W'(off_reg);
                        end
                    end
                    smm_pkg::CMD_LOADPROG: begin
                        if (!mapped || !in_use_reg[0]) begin
                            op_rsp.status = smm_pkg::ST_UNMAPPED;
                        end else if (idx != '0) begin
                            op_kind  = smm_pkg::OP_COPY;
                            op_addr  = base;
                            op_count = size_rd_reg;
                            size_we  = commit;
                            size_wa  = '0;
                            size_wd  = size_rd_reg;
                        end
                    end
                    smm_pkg::CMD_LENGTH: begin
                        if (!mapped) op_rsp.status = smm_pkg::ST_UNMAPPED;
                        else op_rsp.data = 32'(size_rd_reg);
                    end
                    default: ;
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            in_use_reg       <= '0;
            free_count_reg   <= '0;
            mapped_count_reg <= '0;
        end else begin
            state_reg        <= state_next;
            in_use_reg       <= in_use_next;
            free_count_reg   <= free_count_next;
            mapped_count_reg <= mapped_count_next;
        end
        if (accept) begin
            cmd_reg <= s_command;
            id_reg  <= s_segment_id;
            off_reg <= s_offset;
            val_reg <= s_value;
            len_reg <= s_length;
        end
    end

    // Bookkeeping tables: read on acceptance, written when the operation is issued.
    always_ff @(posedge aclk) begin
        if (size_we) size_mem[size_wa] <= size_wd;
        if (stack_we) stack_mem[stack_wa] <= stack_wd;
        if (accept) begin
            size_rd_reg  <= size_mem[SLOT_W'({24'b0, s_segment_id})];
            stack_rd_reg <= stack_mem[SLOT_W'(free_count_reg - 1'b1)];
        end
    end

endmodule

>>> rtl/core/smm_queue.sv
// Short queue of issued operations between front and back end.
`include "assert_macros.svh"

module smm_queue #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(smm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(smm_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [smm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(smm_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    `SMM_NEVER(a_no_push_full, aclk, aresetn, push && full)
    `SMM_NEVER(a_no_pop_empty, aclk, aresetn, pop && empty)
    `SMM_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(smm_pkg::QUEUE_DEPTH))

endmodule

>>> rtl/core/smm_back.sv
// Back end: word memory, zero fill, program copy and result register.
module smm_back #(
    parameter int SEGMENT_SLOTS = 256,
    parameter int SEGMENT_WORDS = 1024,
    parameter int LEN_W         = $clog2(SEGMENT_WORDS + 1),
    parameter int ADDR_W        = $clog2(longint'(SEGMENT_SLOTS) * longint'(SEGMENT_WORDS))
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    output logic              q_pop,
    input  smm_pkg::op_kind_t q_kind,
    input  logic [ADDR_W-1:0] q_addr,
    input  logic [LEN_W-1:0]  q_count,
    input  logic [31:0]       q_value,
    input  smm_pkg::rsp_t     q_rsp,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_data,
    output logic [2:0]        m_status
);

    localparam longint DEPTH = longint'(SEGMENT_SLOTS) * longint'(SEGMENT_WORDS);

    typedef enum logic [1:0] {B_IDLE, B_LOAD, B_FILL, B_COPY} state_t;

    logic [31:0]       mem [0:DEPTH-1];
    logic [31:0]       rd_data_reg;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              wr_pend_reg, wr_pend_next;
    smm_pkg::rsp_t     rsp_reg, rsp_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;
    logic [2:0]        m_status_reg, m_status_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [31:0]       mem_wd;
    logic              out_free, set_out, more;
    smm_pkg::rsp_t     out_rsp;

    assign out_free = !m_valid_reg || m_ready;
    assign more     = (cnt_reg < count_reg);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        wr_pend_next = wr_pend_reg;
        rsp_next     = rsp_reg;
        q_pop   = 1'b0;
        set_out = 1'b0;
        out_rsp = rsp_reg;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = '0;
        mem_ra  = '0;

        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop     = 1'b1;
                    addr_next = q_addr;
                    count_next = q_count;
                    cnt_next  = '0;
                    wr_pend_next = 1'b0;
                    rsp_next  = q_rsp;
                    unique case (q_kind)
                        smm_pkg::OP_LOAD: begin
                            mem_ra     = q_addr;
                            state_next = B_LOAD;
                        end
                        smm_pkg::OP_STORE: begin
                            mem_we  = 1'b1;
                            mem_wa  = q_addr;
                            mem_wd  = q_value;
                            set_out = 1'b1;
                            out_rsp = q_rsp;
                        end
                        smm_pkg::OP_FILL: state_next = B_FILL;
                        smm_pkg::OP_COPY: state_next = B_COPY;
                        default: begin
                            set_out = 1'b1;
                            out_rsp = q_rsp;
                        end
                    endcase
                end
            end
            B_LOAD: begin
                set_out    = 1'b1;
                out_rsp    = '{data: rd_data_reg, status: smm_pkg::ST_OK};
                state_next = B_IDLE;
            end
            B_FILL: begin
                if (more) begin
                    mem_we   = 1'b1;
                    mem_wa   = addr_reg + ADDR_W'(cnt_reg);
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    set_out    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_COPY: begin
                // Read source word n while writing word n-1 into segment 0.
                mem_ra = addr_reg + ADDR_W'(cnt_reg);
                if (wr_pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = ADDR_W'(cnt_reg - 1'b1);
                    mem_wd = rd_data_reg;
                end
                wr_pend_next = more;
                if (more) cnt_next = cnt_reg + 1'b1;
                if (!more && !wr_pend_reg) begin
                    set_out    = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        m_valid_next  = set_out ? 1'b1 : (m_valid_reg && !m_ready);
        m_data_next   = set_out ? out_rsp.data : m_data_reg;
        m_status_next = set_out ? out_rsp.status : m_status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg     <= addr_next;
        count_reg    <= count_next;
        cnt_reg      <= cnt_next;
        rsp_reg      <= rsp_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

endmodule

>>> rtl/core/segmented_memory_manager.sv
// Segmented memory manager: one result per request, decoupled front and back end.
// Front end: accepts a request, then looks it up and issues it into the queue; it takes no
// new request until that one is issued. Back end: length, unmap, store and error results
// come straight from the queue entry, a load reads memory first, and map and load program
// first write their n words (zero fill, or copy into segment 0) before the result is set.
// Reset (aresetn low at a clock edge) clears bookkeeping; word memory is not cleared.
module segmented_memory_manager #(
    parameter int SEGMENT_SLOTS = 256,
    parameter int SEGMENT_WORDS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_segment_id,
    input  logic [9:0]  s_offset,
    input  logic [31:0] s_value,
    input  logic [10:0] s_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_data,
    output logic [2:0]  m_status
);

    localparam int SLOT_W = $clog2(SEGMENT_SLOTS);
    localparam int LEN_W  = $clog2(SEGMENT_WORDS + 1);
    localparam int ADDR_W = $clog2(longint'(SEGMENT_SLOTS) * longint'(SEGMENT_WORDS));
    localparam int RSP_W  = $bits(smm_pkg::rsp_t);
    localparam int OP_W   = 3 + ADDR_W + LEN_W + 32 + RSP_W;

    logic              q_full, q_push, q_pop, q_empty;
    smm_pkg::op_kind_t op_kind;
    logic [ADDR_W-1:0] op_addr;
    logic [LEN_W-1:0]  op_count;
    logic [31:0]       op_value;
    smm_pkg::rsp_t     op_rsp;
    logic [OP_W-1:0]   push_data, pop_data;

    assign push_data = {op_kind, op_addr, op_count, op_value, op_rsp};

    smm_front #(
        .SEGMENT_SLOTS(SEGMENT_SLOTS),
        .SEGMENT_WORDS(SEGMENT_WORDS),
        .SLOT_W(SLOT_W),
        .LEN_W(LEN_W),
        .ADDR_W(ADDR_W)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_segment_id(s_segment_id),
        .s_offset(s_offset),
        .s_value(s_value),
        .s_length(s_length),
        .q_full(q_full),
        .q_push(q_push),
        .op_kind(op_kind),
        .op_addr(op_addr),
        .op_count(op_count),
        .op_value(op_value),
        .op_rsp(op_rsp)
    );

    smm_queue #(
        .WIDTH(OP_W)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .push_data(push_data),
        .full(q_full),
        .pop(q_pop),
        .pop_data(pop_data),
        .empty(q_empty)
    );

    smm_back #(
        .SEGMENT_SLOTS(SEGMENT_SLOTS),
        .SEGMENT_WORDS(SEGMENT_WORDS),
        .LEN_W(LEN_W),
        .ADDR_W(ADDR_W)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_pop(q_pop),
        .q_kind(smm_pkg::op_kind_t'(pop_data[OP_W-1 -: 3])),
        .q_addr(pop_data[OP_W-4 -: ADDR_W]),
        .q_count(pop_data[OP_W-4-ADDR_W -: LEN_W]),
        .q_value(pop_data[RSP_W+31 -: 32]),
        .q_rsp(smm_pkg::rsp_t'(pop_data[RSP_W-1:0])),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .m_status(m_status)
    );

endmodule
